// ----- design/ncd_pkg.sv -----
package ncd_pkg;

   localparam int NODE_W   = 10;
   localparam int WEIGHT_W = 16;
   localparam int COUNT_W  = 11;
   localparam int DIST_W   = 52;

   localparam logic signed [DIST_W-1:0] FAR_DISTANCE = 52'sd1000000000000000;
   localparam logic signed [DIST_W-1:0] DIST_MAX     = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN     = {1'b1, {(DIST_W-1){1'b0}}};

   typedef struct packed {
      logic [NODE_W-1:0]          first_node;
      logic [NODE_W-1:0]          second_node;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   localparam int EDGE_W = $bits(edge_type);

endpackage

// ----- design/ncd_req_if.sv -----
interface ncd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ncd_pkg::NODE_W-1:0]           first_node;
   logic [ncd_pkg::NODE_W-1:0]           second_node;
   logic signed [ncd_pkg::WEIGHT_W-1:0]  weight;
   logic                                 last_edge;

   modport source (output valid, output first_node, output second_node, output weight,
                   output last_edge, input ready);
   modport sink   (input valid, input first_node, input second_node, input weight,
                   input last_edge, output ready);
endinterface

// ----- design/ncd_rsp_if.sv -----
interface ncd_rsp_if;
   logic valid;
   logic ready;
   logic negative_cycle;

   modport source (output valid, output negative_cycle, input ready);
   modport sink   (input valid, input negative_cycle, output ready);
endinterface

// ----- design/ncd_ram.sv -----
module ncd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [WIDTH-1:0]    rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ncd_relax.sv -----
module ncd_relax (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [ncd_pkg::DIST_W-1:0]   dist_lower,
   input  logic signed [ncd_pkg::DIST_W-1:0]   dist_offer,
   input  logic signed [ncd_pkg::WEIGHT_W-1:0] weight,
   output logic                                relax,
   output logic signed [ncd_pkg::DIST_W-1:0]   cand
);
   localparam int DW = ncd_pkg::DIST_W;
   localparam int WW = ncd_pkg::WEIGHT_W;

   logic signed [DW:0]   sum;
   logic signed [DW-1:0] sat_sum;
   logic signed [DW-1:0] cand_ff;
   logic signed [DW-1:0] cand_in;
   logic signed [DW-1:0] lower_ff;
   logic signed [DW-1:0] lower_in;

   always_comb begin
      sum = {dist_offer[DW-1], dist_offer} + {{(DW+1-WW){weight[WW-1]}}, weight};
      if (sum[DW] != sum[DW-1]) begin
         sat_sum = sum[DW] ? ncd_pkg::DIST_MIN : ncd_pkg::DIST_MAX;
      end else begin
         sat_sum = sum[DW-1:0];
      end
      cand_in  = load ? sat_sum : cand_ff;
      lower_in = load ? dist_lower : lower_ff;
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      lower_ff <= lower_in;
   end

   assign relax = lower_ff > cand_ff;
   assign cand  = cand_ff;

endmodule

// ----- design/negative_cycle_detector.sv -----
// Negative cycle detector over a loaded edge list.
//
// req_chan carries one weighted edge per transfer; edges load at one per cycle
// into the edge memory. The last_edge transfer closes the list and starts the
// search; req_chan.ready stays low until the search is over. The user must set
// node_count (csr_wr_en/csr_wr_data) only while idle; the block does not check.
//
// Search: seed the distance memory, then node_count-1 relaxing passes and one
// checking pass over the stored edges (node_count is clamped to 1..MAX_NODES).
// Each edge with both nodes in range goes through distance read, add and
// saturate, and compare and write back (only a flag in the checking pass); an
// out-of-range edge moves on after the distance read step. The edge memory
// read and the distance memory read-modify-write set these steps.
//
// rsp_chan delivers one negative_cycle flag per list. The result register lets
// the next list load while a result waits; a finished search holds until the
// register is free. Reset clears the edge count, empties the result register
// and sets node_count to 1; memory contents are not cleared.
module negative_cycle_detector #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ncd_pkg::COUNT_W-1:0]   csr_wr_data,
   ncd_req_if.sink                       req_chan,
   ncd_rsp_if.source                     rsp_chan
);
   localparam int DAW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int DW  = ncd_pkg::DIST_W;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_DRD   = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [ncd_pkg::COUNT_W-1:0] node_count_ff, node_count_in;
   logic [NCW-1:0]              nodes_ff, nodes_in;
   logic [ECW-1:0]              edge_total_ff, edge_total_in;
   logic [ECW-1:0]              idx_ff, idx_in;
   logic [NCW-1:0]              init_ff, init_in;
   logic [NCW-1:0]              pass_ff, pass_in;
   logic                        found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_data_ff, rsp_data_in;

   logic                        req_xfer;
   logic                        rsp_free;
   logic [NCW-1:0]              nodes_eff;
   logic                        edge_we;
   logic                        edge_rd_en;
   logic [EAW-1:0]              edge_raddr;
   logic [ncd_pkg::EDGE_W-1:0]  edge_rd_bits;
   ncd_pkg::edge_type           edge_rd;
   ncd_pkg::edge_type           edge_wr;
   logic                        in_range;
   logic                        more_edges;
   logic                        check_pass;
   logic                        dist_rd_en;
   logic                        dist_we;
   logic [DAW-1:0]              dist_waddr;
   logic signed [DW-1:0]        dist_wdata;
   logic signed [DW-1:0]        dist_lower;
   logic signed [DW-1:0]        dist_offer;
   logic                        relax_load;
   logic                        relax;
   logic signed [DW-1:0]        cand;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.negative_cycle = rsp_data_ff;

   assign edge_wr.first_node  = req_chan.first_node;
   assign edge_wr.second_node = req_chan.second_node;
   assign edge_wr.weight      = req_chan.weight;
   assign edge_we = req_xfer && (32'(edge_total_ff) < MAX_EDGES);
   assign edge_rd = ncd_pkg::edge_type'(edge_rd_bits);

   assign in_range   = (32'(edge_rd.first_node) < 32'(nodes_ff))
                       && (32'(edge_rd.second_node) < 32'(nodes_ff));
   assign more_edges = (32'(idx_ff) + 32'd1) < 32'(edge_total_ff);
   assign check_pass = (32'(pass_ff) + 32'd1) == 32'(nodes_ff);
   assign dist_rd_en = (state_ff == ST_DRD) && in_range;
   assign relax_load = (state_ff == ST_CMP);

   always_comb begin
      if (node_count_ff == '0) begin
         nodes_eff = NCW'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         nodes_eff = NCW'(MAX_NODES);
      end else begin
         nodes_eff = NCW'(node_count_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      nodes_in      = nodes_ff;
      edge_total_in = edge_total_ff;
      idx_in        = idx_ff;
      init_in       = init_ff;
      pass_in       = pass_ff;
      found_in      = found_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      edge_rd_en    = 1'b0;
      edge_raddr    = idx_ff[EAW-1:0];
      dist_we       = 1'b0;
      dist_waddr    = init_ff[DAW-1:0];
      dist_wdata    = (init_ff == '0) ? '0 : ncd_pkg::FAR_DISTANCE;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (edge_we) begin
                  edge_total_in = edge_total_ff + ECW'(1);
               end
               if (req_chan.last_edge) begin
                  nodes_in = nodes_eff;
                  init_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            dist_we = 1'b1;
            if ((32'(init_ff) + 32'd1) == 32'(nodes_ff)) begin
               idx_in   = '0;
               pass_in  = '0;
               state_in = ST_FETCH;
            end else begin
               init_in = init_ff + NCW'(1);
            end
         end
         ST_FETCH: begin
            edge_rd_en = 1'b1;
            state_in   = ST_DRD;
         end
         ST_DRD, ST_UPD: begin
            if (state_ff == ST_UPD && relax) begin
               if (check_pass) begin
                  found_in = 1'b1;
               end else begin
                  dist_we    = 1'b1;
                  dist_waddr = DAW'(edge_rd.first_node);
                  dist_wdata = cand;
               end
            end
            if (state_ff == ST_DRD && in_range) begin
               state_in = ST_CMP;
            end else if (more_edges) begin
               idx_in     = idx_ff + ECW'(1);
               edge_rd_en = 1'b1;
               edge_raddr = idx_in[EAW-1:0];
               state_in   = ST_DRD;
            end else if (check_pass) begin
               state_in = ST_DONE;
            end else begin
               pass_in    = pass_ff + NCW'(1);
               idx_in     = '0;
               edge_rd_en = 1'b1;
               edge_raddr = '0;
               state_in   = ST_DRD;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = found_ff;
               edge_total_in = '0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         node_count_ff <= ncd_pkg::COUNT_W'(1);
         nodes_ff      <= NCW'(1);
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         nodes_ff      <= nodes_in;
         edge_total_ff <= edge_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      init_ff     <= init_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
   end

   ncd_ram #(.WIDTH(ncd_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_total_ff[EAW-1:0]),
      .wr_data (edge_wr),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_raddr),
      .rd_data (edge_rd_bits)
   );

   ncd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_lower_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_en   (dist_rd_en),
      .rd_addr (DAW'(edge_rd.first_node)),
      .rd_data (dist_lower)
   );

   ncd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_offer_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_en   (dist_rd_en),
      .rd_addr (DAW'(edge_rd.second_node)),
      .rd_data (dist_offer)
   );

   ncd_relax u_relax (
      .clock      (clock),
      .load       (relax_load),
      .dist_lower (dist_lower),
      .dist_offer (dist_offer),
      .weight     (edge_rd.weight),
      .relax      (relax),
      .cand       (cand)
   );

   a_dist_write_in_range: assert property (@(posedge clock) disable iff (reset)
      dist_we |-> (32'(dist_waddr) < 32'(nodes_ff)))
      else $error("distance write outside the active node range");

   a_edge_index_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRD) |-> (32'(idx_ff) < 32'(edge_total_ff)))
      else $error("edge index beyond the stored list");

   a_check_pass_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && check_pass) |-> !dist_we)
      else $error("distance write during the checking pass");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_LOAD
                                            && edge_total_ff == '0))
      else $error("finished search did not load the result register");

   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(edge_total_ff) <= MAX_EDGES)
      else $error("edge count beyond capacity");

endmodule
